// ===== rtl/json_structure_event_parser_defines.svh =====
// Assertion macros for the JSON structure event parser.
`ifndef JSON_STRUCTURE_EVENT_PARSER_DEFINES_SVH
`define JSON_STRUCTURE_EVENT_PARSER_DEFINES_SVH

// Condition holds at every edge out of reset.
`define JSEP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("jsep: invariant violated");

// Antecedent implies consequent at the same edge.
`define JSEP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsep: implication violated");

// Antecedent implies consequent at the next edge.
`define JSEP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsep: next-cycle implication violated");

`endif

// ===== rtl/jsep_pkg.sv =====
// Types, codes and sizes shared by the JSON structure event parser.
`default_nettype none

package jsep_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [2:0] TK_STRING  = 3'd0;
  localparam logic [2:0] TK_SPACE   = 3'd4;
  localparam logic [2:0] TK_PUNCT   = 3'd5;
  localparam logic [2:0] TK_COMMENT = 3'd6;

  localparam logic [2:0] P_COLON    = 3'd0;
  localparam logic [2:0] P_COMMA    = 3'd1;
  localparam logic [2:0] P_LBRACE   = 3'd2;
  localparam logic [2:0] P_RBRACE   = 3'd3;
  localparam logic [2:0] P_LBRACKET = 3'd4;
  localparam logic [2:0] P_RBRACKET = 3'd5;

  typedef enum logic [2:0] {
    PH_VALUE     = 3'd0,
    PH_LIST_OPEN = 3'd1,
    PH_OBJ_OPEN  = 3'd2,
    PH_KEY       = 3'd3,
    PH_COLON     = 3'd4,
    PH_CLOSURE   = 3'd5
  } phase_t;

  localparam logic [2:0] PH_ERROR_CODE = 3'd6;

  typedef enum logic [2:0] {
    EV_OBJ_BEGIN  = 3'd0,
    EV_KEY        = 3'd1,
    EV_OBJ_END    = 3'd2,
    EV_LIST_BEGIN = 3'd3,
    EV_LIST_END   = 3'd4,
    EV_VALUE      = 3'd5
  } ev_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_INTERNAL   = 2'd1,
    ERR_UNEXPECTED = 2'd2,
    ERR_BAD_STATE  = 2'd3
  } err_t;

  typedef struct packed {
    logic     event_valid;
    ev_kind_t event_kind;
    err_t     error_code;
  } result_t;

  typedef struct packed {
    logic   push;
    logic   push_list;
    logic   pop;
    logic   set_phase;
    phase_t phase;
  } upd_t;

endpackage

`default_nettype wire

// ===== rtl/jsep_token_if.sv =====
// Token input channel: valid/ready with one lexed token.
`default_nettype none

interface jsep_token_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [2:0] punct_code;
  logic       peek_only;

  modport source (output valid, output token_kind, output punct_code, output peek_only,
                  input ready);
  modport sink (input valid, input token_kind, input punct_code, input peek_only,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/jsep_event_if.sv =====
// Result output channel: valid/ready with one structural event result.
`default_nettype none

interface jsep_event_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [2:0] event_kind;
  logic [1:0] error_code;

  modport source (output valid, output event_valid, output event_kind, output error_code,
                  input ready);
  modport sink (input valid, input event_valid, input event_kind, input error_code,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/json_structure_event_parser.sv =====
// Top level of the JSON structure event parser.
//
//   port  dir  transfer                     payload
//   tok   in   tok.valid & tok.ready        token_kind, punct_code, peek_only
//   evt   out  evt.valid & evt.ready        event_valid, event_kind, error_code
//
// One token per cycle while evt takes results; a token passes the input register, then
// the result register, before its result is on evt.
// The stack top is held in a flop; entries below sit in a registered-read RAM
// addressed one below the top, with a bypass after a push.
// Reset clears phase, depth and valid flags; stack contents need no clearing.
// A stalled result holds in the output register while one more token waits
// in the input register.
`default_nettype none
`include "json_structure_event_parser_defines.svh"

module json_structure_event_parser (
  input  wire logic   clk,
  input  wire logic   rst,
  jsep_token_if.sink  tok,
  jsep_event_if.source evt
);

  localparam int DW = jsep_pkg::DEPTH_W;
  localparam int AW = jsep_pkg::ADDR_W;

  logic       s1_valid;
  logic [2:0] s1_kind;
  logic [2:0] s1_punct;
  logic       s1_peek;

  logic              o_valid;
  jsep_pkg::result_t o_res;

  jsep_pkg::phase_t phase;
  jsep_pkg::phase_t phase_next;
  logic [DW-1:0]    depth;
  logic [DW-1:0]    depth_next;
  logic             top_mark;
  logic             top_mark_next;
  logic             byp;
  logic             byp_data;

  logic advance;
  logic fire;
  logic below;

  jsep_pkg::result_t res;
  jsep_pkg::upd_t    upd;

  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [DW-1:0] raddr_full;
  logic [DW-1:0] waddr_full;
  logic          rdata;

  assign advance   = !o_valid || evt.ready;
  assign fire      = s1_valid && advance;
  assign tok.ready = !s1_valid || advance;

  jsep_step u_step (
    .token_kind (s1_kind),
    .punct_code (s1_punct),
    .peek_only  (s1_peek),
    .phase      (phase),
    .depth      (depth),
    .top_mark   (top_mark),
    .res        (res),
    .upd        (upd)
  );

  assign below = byp ? byp_data : rdata;

  always_comb begin
    phase_next    = phase;
    depth_next    = depth;
    top_mark_next = top_mark;
    if (fire) begin
      if (upd.set_phase) begin
        phase_next = upd.phase;
      end
      if (upd.push) begin
        depth_next    = depth + DW'(1);
        top_mark_next = upd.push_list;
      end else if (upd.pop) begin
        depth_next    = depth - DW'(1);
        top_mark_next = below;
      end
    end
  end

  assign we         = fire && upd.push && (depth != '0);
  assign waddr_full = depth - DW'(1);
  assign waddr      = waddr_full[AW-1:0];
  assign raddr_full = depth_next - DW'(2);
  assign raddr      = raddr_full[AW-1:0];

  jsep_ram #(
    .WIDTH (1),
    .DEPTH (jsep_pkg::STACK_DEPTH),
    .AW    (AW)
  ) u_marks (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top_mark),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
      phase    <= jsep_pkg::PH_VALUE;
      depth    <= '0;
      byp      <= 1'b0;
    end else begin
      if (tok.ready) begin
        s1_valid <= tok.valid;
      end
      if (advance) begin
        o_valid <= s1_valid;
      end
      phase <= phase_next;
      depth <= depth_next;
      byp   <= we;
    end
  end

  always_ff @(posedge clk) begin
    if (tok.valid && tok.ready) begin
      s1_kind  <= tok.token_kind;
      s1_punct <= tok.punct_code;
      s1_peek  <= tok.peek_only;
    end
    if (fire) begin
      o_res <= res;
    end
    top_mark <= top_mark_next;
    byp_data <= top_mark;
  end

  assign evt.valid       = o_valid;
  assign evt.event_valid = o_res.event_valid;
  assign evt.event_kind  = 3'(o_res.event_kind);
  assign evt.error_code  = 2'(o_res.error_code);

  `JSEP_ASSERT_ALWAYS(a_depth_bound, depth <= DW'(jsep_pkg::STACK_DEPTH))
  `JSEP_ASSERT_NEXT(a_state_hold, !fire, $stable(depth) && $stable(phase))
  `JSEP_ASSERT_IMPL(a_err_no_event, o_valid && o_res.error_code != jsep_pkg::ERR_NONE,
                    !o_res.event_valid)
  `JSEP_ASSERT_NEXT(a_peek_no_change, fire && s1_peek, $stable(depth) && $stable(phase))

endmodule

`default_nettype wire

// ===== rtl/jsep_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module jsep_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/jsep_step.sv =====
// Per-token transition logic: result and state update for one token.
`default_nettype none

module jsep_step (
  input  wire logic [2:0]                   token_kind,
  input  wire logic [2:0]                   punct_code,
  input  wire logic                         peek_only,
  input  wire jsep_pkg::phase_t             phase,
  input  wire logic [jsep_pkg::DEPTH_W-1:0] depth,
  input  wire logic                         top_mark,
  output jsep_pkg::result_t                 res,
  output jsep_pkg::upd_t                    upd
);

  logic has_top;
  logic tlist;
  logic full;
  logic punct;

  assign has_top = (depth != '0);
  assign tlist   = has_top && top_mark;
  assign full    = (depth == jsep_pkg::DEPTH_W'(jsep_pkg::STACK_DEPTH));
  assign punct   = (token_kind == jsep_pkg::TK_PUNCT);

  always_comb begin
    logic do_push;
    logic push_list;
    logic do_pop;
    jsep_pkg::ev_kind_t pop_ev;

    res       = '{event_valid: 1'b0, event_kind: jsep_pkg::EV_OBJ_BEGIN,
                  error_code: jsep_pkg::ERR_NONE};
    upd       = '{push: 1'b0, push_list: 1'b0, pop: 1'b0, set_phase: 1'b0,
                  phase: jsep_pkg::PH_VALUE};
    do_push   = 1'b0;
    push_list = 1'b0;
    do_pop    = 1'b0;
    pop_ev    = jsep_pkg::EV_LIST_END;

    if (token_kind == jsep_pkg::TK_SPACE || token_kind == jsep_pkg::TK_COMMENT) begin
      // skipped token
    end else begin
      case (phase)
        jsep_pkg::PH_VALUE, jsep_pkg::PH_LIST_OPEN: begin
          if (phase == jsep_pkg::PH_LIST_OPEN && punct && tlist &&
              punct_code == jsep_pkg::P_RBRACKET) begin
            do_pop = 1'b1;
            pop_ev = jsep_pkg::EV_LIST_END;
          end else if (punct) begin
            if (punct_code == jsep_pkg::P_LBRACE) begin
              do_push = 1'b1;
            end else if (punct_code == jsep_pkg::P_LBRACKET) begin
              do_push   = 1'b1;
              push_list = 1'b1;
            end else begin
              res.error_code = jsep_pkg::ERR_UNEXPECTED;
            end
          end else begin
            res.event_valid = 1'b1;
            res.event_kind  = jsep_pkg::EV_VALUE;
            upd.set_phase   = !peek_only;
            upd.phase       = jsep_pkg::PH_CLOSURE;
          end
        end
        jsep_pkg::PH_OBJ_OPEN, jsep_pkg::PH_KEY: begin
          if (phase == jsep_pkg::PH_OBJ_OPEN && punct && has_top && !tlist &&
              punct_code == jsep_pkg::P_RBRACE) begin
            do_pop = 1'b1;
            pop_ev = jsep_pkg::EV_OBJ_END;
          end else if (token_kind != jsep_pkg::TK_STRING) begin
            res.error_code = jsep_pkg::ERR_UNEXPECTED;
          end else if (!has_top || tlist) begin
            res.error_code = jsep_pkg::ERR_INTERNAL;
          end else begin
            res.event_valid = 1'b1;
            res.event_kind  = jsep_pkg::EV_KEY;
            upd.set_phase   = !peek_only;
            upd.phase       = jsep_pkg::PH_COLON;
          end
        end
        jsep_pkg::PH_COLON: begin
          if (!punct || punct_code != jsep_pkg::P_COLON) begin
            res.error_code = jsep_pkg::ERR_UNEXPECTED;
          end else begin
            upd.set_phase = !peek_only;
            upd.phase     = jsep_pkg::PH_VALUE;
          end
        end
        jsep_pkg::PH_CLOSURE: begin
          if (!punct) begin
            res.error_code = jsep_pkg::ERR_UNEXPECTED;
          end else if (!has_top) begin
            res.error_code = jsep_pkg::ERR_INTERNAL;
          end else if (punct_code == jsep_pkg::P_COMMA) begin
            upd.set_phase = !peek_only;
            upd.phase     = tlist ? jsep_pkg::PH_VALUE : jsep_pkg::PH_KEY;
          end else if (tlist) begin
            if (punct_code != jsep_pkg::P_RBRACKET) begin
              res.error_code = jsep_pkg::ERR_UNEXPECTED;
            end else begin
              do_pop = 1'b1;
              pop_ev = jsep_pkg::EV_LIST_END;
            end
          end else begin
            if (punct_code != jsep_pkg::P_RBRACE) begin
              res.error_code = jsep_pkg::ERR_UNEXPECTED;
            end else begin
              do_pop = 1'b1;
              pop_ev = jsep_pkg::EV_OBJ_END;
            end
          end
        end
        default: begin
          res.error_code = (phase == jsep_pkg::PH_ERROR_CODE) ?
                           jsep_pkg::ERR_BAD_STATE : jsep_pkg::ERR_INTERNAL;
        end
      endcase
    end

    if (do_push) begin
      if (!peek_only && full) begin
        res.error_code = jsep_pkg::ERR_INTERNAL;
      end else begin
        res.event_valid = 1'b1;
        res.event_kind  = push_list ? jsep_pkg::EV_LIST_BEGIN : jsep_pkg::EV_OBJ_BEGIN;
        upd.push        = !peek_only;
        upd.push_list   = push_list;
        upd.set_phase   = !peek_only;
        upd.phase       = push_list ? jsep_pkg::PH_LIST_OPEN : jsep_pkg::PH_OBJ_OPEN;
      end
    end

    if (do_pop) begin
      res.event_valid = 1'b1;
      res.event_kind  = pop_ev;
      upd.pop         = !peek_only && has_top;
      upd.set_phase   = !peek_only;
      upd.phase       = jsep_pkg::PH_CLOSURE;
    end
  end

endmodule

`default_nettype wire
